// File: hdl/ppl_pkg.sv
`timescale 1ns / 1ps

package ppl_pkg;

	// store geometry
	localparam int POINTS_DEF = 64;
	localparam int COORD_W    = 16;
	localparam int INDEX_W    = 6;
	localparam int COUNT_W    = 7;
	localparam int SHADE_W    = 8;
	localparam int POINT_W    = 2 * COORD_W;

	// shared multiplier
	localparam int MUL_W  = 24;
	localparam int PROD_W = 2 * MUL_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 1'd1;

	localparam logic [COORD_W-1:0] MIN_DISTANCE_RST = 16'd1600;
	localparam logic [COUNT_W-1:0] POINT_COUNT_RST  = 7'd64;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ROW  = 1'b1;

	// row sequencer
	typedef enum logic [3:0] {
		S_IDLE,
		S_RDA,
		S_M2,
		S_FETCH,
		S_DX,
		S_DY,
		S_CMP,
		S_RHS,
		S_SM1,
		S_SM2,
		S_SM3,
		S_PUSH,
		S_FIN
	} state_t;

endpackage

// File: hdl/ppl_req_if.sv
`timescale 1ns / 1ps

interface ppl_req_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [ppl_pkg::INDEX_W-1:0]  index;
	logic [ppl_pkg::COORD_W-1:0]  pos_x;
	logic [ppl_pkg::COORD_W-1:0]  pos_y;

	modport source (output valid, command, index, pos_x, pos_y, input ready);
	modport sink (input valid, command, index, pos_x, pos_y, output ready);
endinterface

// File: hdl/ppl_rsp_if.sv
`timescale 1ns / 1ps

interface ppl_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [ppl_pkg::COORD_W-1:0]  start_x;
	logic [ppl_pkg::COORD_W-1:0]  start_y;
	logic [ppl_pkg::COORD_W-1:0]  end_x;
	logic [ppl_pkg::COORD_W-1:0]  end_y;
	logic [ppl_pkg::SHADE_W-1:0]  shade;
	logic                         last;

	modport source (output valid, found, start_x, start_y, end_x, end_y, shade, last,
		input ready);
	modport sink (input valid, found, start_x, start_y, end_x, end_y, shade, last,
		output ready);
endinterface

// File: hdl/ppl_cfg_if.sv
`timescale 1ns / 1ps

interface ppl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ppl_pkg::CFG_IDX_W-1:0]   index;
	logic [ppl_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ppl_ram.sv
`timescale 1ns / 1ps

// single write port, single registered read port
module ppl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/point_pair_proximity_lines.sv
`timescale 1ns / 1ps

// Fixed-radius neighbor pair search over a small point store.
// req channel: command LOAD writes (pos_x, pos_y) into slot index and
// gives no result; loads to slots at or past POINTS are dropped. Command ROW walks
// partners j = index+1 .. count-1 (count = min(point_count, POINTS)) and sends one
// rsp beat per pair closer than min_distance, carrying both endpoints and
// shade = floor(255*d/min_distance); the final beat of a row has last=1, and a row
// without pairs gives a single beat with found=0, last=1 and zero payload.
// cfg channel: always ready; index 0 = min_distance, 1 = point_count. Write it only
// while no row is in progress.
// Timing: req.ready is high only in idle. A row's length is set by the single
// shared 24x24 multiplier: each partner needs dx^2 and dy^2 from it, and each
// pair runs an 8-step bit search for the shade, through SM1, SM2 and SM3 per bit.
// Results are held one deep internally so last can be set on the final pair; a
// stalled rsp receiver stalls the sequencer at the next result, nothing is lost.
// Reset clears the sequencer, empties the output register and loads the register
// defaults (1600, 64). The point store keeps no reset; unloaded slots read garbage.
module point_pair_proximity_lines #(
	parameter int POINTS = ppl_pkg::POINTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ppl_req_if.sink   req,
	ppl_rsp_if.source rsp,
	ppl_cfg_if.sink   cfg
);

	localparam int AW = $clog2(POINTS);
	localparam logic [ppl_pkg::COUNT_W-1:0] POINTS_V = ppl_pkg::COUNT_W'(POINTS);

	localparam int CW = ppl_pkg::COORD_W;
	localparam int MW = ppl_pkg::MUL_W;
	localparam int PW = ppl_pkg::PROD_W;
	localparam int SW = ppl_pkg::SHADE_W;
	localparam int NW = ppl_pkg::COUNT_W;

	ppl_pkg::state_t state_q, state_n;

	// configuration
	logic [CW-1:0] min_distance_q;
	logic [NW-1:0] point_count_q;
	logic [NW-1:0] cnt;

	// control
	logic          out_valid_q;
	logic          pend_valid_q;
	logic          out_free;
	logic          out_load;
	logic          out_from_pend;
	logic          pend_load;
	logic          j_step;

	// datapath
	logic [NW-1:0]   j_q;
	logic [NW-1:0]   j_next;
	logic [CW-1:0]   ax_q, ay_q, bx_q, by_q, dy_q;
	logic [CW-1:0]   dx, dy;
	logic [31:0]     m2_q;
	logic [32:0]     d2_q;
	logic [32:0]     d2_sum;
	logic [PW-1:0]   rhs_q;
	logic [PW-1:0]   prod_q;
	logic [MW-1:0]   mul_a, mul_b;
	logic [SW-1:0]   v_q, bit_q, v_new, shade_q;
	logic [CW-1:0]   pend_x_q, pend_y_q;
	logic [SW-1:0]   pend_shade_q;

	// output register
	logic            out_found_q, out_last_q;
	logic [CW-1:0]   out_sx_q, out_sy_q, out_ex_q, out_ey_q;
	logic [SW-1:0]   out_shade_q;

	// point store
	logic                          st_we;
	logic [AW-1:0]                 st_raddr;
	logic [ppl_pkg::POINT_W-1:0]   st_rdata;

	logic req_fire;

	assign req_fire = req.valid && req.ready;
	assign cnt      = (point_count_q > POINTS_V) ? POINTS_V : point_count_q;
	assign out_free = !out_valid_q || rsp.ready;
	assign j_next   = NW'(j_q + 1'b1);

	assign st_we = req_fire && (req.command == ppl_pkg::CMD_LOAD)
		&& ({1'b0, req.index} < POINTS_V);

	ppl_ram #(
		.WIDTH (ppl_pkg::POINT_W),
		.DEPTH (POINTS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (req.index[AW-1:0]),
		.wdata ({req.pos_y, req.pos_x}),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// distance terms and shade trial
	assign dx     = (ax_q > st_rdata[CW-1:0]) ? ax_q - st_rdata[CW-1:0]
		: st_rdata[CW-1:0] - ax_q;
	assign dy     = (ay_q > st_rdata[2*CW-1:CW]) ? ay_q - st_rdata[2*CW-1:CW]
		: st_rdata[2*CW-1:CW] - ay_q;
	assign d2_sum = d2_q + {1'b0, prod_q[31:0]};
	assign v_new  = (prod_q <= rhs_q) ? (v_q | bit_q) : v_q;

	// sequencer: next state, multiplier operands, strobes
	always_comb begin
		state_n       = state_q;
		req.ready     = 1'b0;
		st_raddr      = j_q[AW-1:0];
		mul_a         = '0;
		mul_b         = '0;
		out_load      = 1'b0;
		out_from_pend = 1'b0;
		pend_load     = 1'b0;
		j_step        = 1'b0;
		case (state_q)
			ppl_pkg::S_IDLE: begin
				req.ready = 1'b1;
				st_raddr  = req.index[AW-1:0];
				if (req.valid && req.command == ppl_pkg::CMD_ROW) begin
					state_n = ({1'b0, req.index} < cnt) ? ppl_pkg::S_RDA : ppl_pkg::S_FIN;
				end
			end
			ppl_pkg::S_RDA: begin
				mul_a   = MW'(min_distance_q);
				mul_b   = MW'(min_distance_q);
				state_n = ppl_pkg::S_M2;
			end
			ppl_pkg::S_M2: begin
				state_n = (j_q >= cnt) ? ppl_pkg::S_FIN : ppl_pkg::S_FETCH;
			end
			ppl_pkg::S_FETCH: begin
				state_n = ppl_pkg::S_DX;
			end
			ppl_pkg::S_DX: begin
				mul_a   = MW'(dx);
				mul_b   = MW'(dx);
				state_n = ppl_pkg::S_DY;
			end
			ppl_pkg::S_DY: begin
				mul_a   = MW'(dy_q);
				mul_b   = MW'(dy_q);
				state_n = ppl_pkg::S_CMP;
			end
			ppl_pkg::S_CMP: begin
				if (d2_sum < {1'b0, m2_q}) begin
					state_n = ppl_pkg::S_RHS;
				end else begin
					j_step  = 1'b1;
					state_n = (j_next >= cnt) ? ppl_pkg::S_FIN : ppl_pkg::S_FETCH;
				end
			end
			ppl_pkg::S_RHS: begin
				state_n = ppl_pkg::S_SM1;
			end
			ppl_pkg::S_SM1: begin
				mul_a   = MW'(v_q | bit_q);
				mul_b   = MW'(min_distance_q);
				state_n = ppl_pkg::S_SM2;
			end
			ppl_pkg::S_SM2: begin
				mul_a   = prod_q[MW-1:0];
				mul_b   = prod_q[MW-1:0];
				state_n = ppl_pkg::S_SM3;
			end
			ppl_pkg::S_SM3: begin
				state_n = bit_q[0] ? ppl_pkg::S_PUSH : ppl_pkg::S_SM1;
			end
			ppl_pkg::S_PUSH: begin
				// hold the newest pair; the previous one goes out as not-last
				if (!pend_valid_q || out_free) begin
					out_load      = pend_valid_q;
					out_from_pend = pend_valid_q;
					pend_load     = 1'b1;
					j_step        = 1'b1;
					state_n       = (j_next >= cnt) ? ppl_pkg::S_FIN : ppl_pkg::S_FETCH;
				end
			end
			ppl_pkg::S_FIN: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_from_pend = pend_valid_q;
					state_n       = ppl_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = ppl_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ppl_pkg::S_IDLE;
			out_valid_q    <= 1'b0;
			pend_valid_q   <= 1'b0;
			min_distance_q <= ppl_pkg::MIN_DISTANCE_RST;
			point_count_q  <= ppl_pkg::POINT_COUNT_RST;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == ppl_pkg::S_FIN && out_free) begin
				pend_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					ppl_pkg::REG_MIN_DISTANCE: min_distance_q <= cfg.data;
					ppl_pkg::REG_POINT_COUNT:  point_count_q  <= cfg.data[NW-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (req_fire) begin
			j_q <= NW'({1'b0, req.index} + 1'b1);
		end else if (j_step) begin
			j_q <= j_next;
		end
		case (state_q)
			ppl_pkg::S_RDA: begin
				ax_q <= st_rdata[CW-1:0];
				ay_q <= st_rdata[2*CW-1:CW];
			end
			ppl_pkg::S_M2: begin
				m2_q <= prod_q[31:0];
			end
			ppl_pkg::S_DX: begin
				bx_q <= st_rdata[CW-1:0];
				by_q <= st_rdata[2*CW-1:CW];
				dy_q <= dy;
			end
			ppl_pkg::S_DY: begin
				d2_q <= {1'b0, prod_q[31:0]};
			end
			ppl_pkg::S_CMP: begin
				d2_q  <= d2_sum;
				v_q   <= '0;
				bit_q <= {1'b1, {(SW-1){1'b0}}};
			end
			ppl_pkg::S_RHS: begin
				// 65025 * d2 = d2 * (2^16 - 2^9 + 1)
				rhs_q <= {d2_q[31:0], 16'b0} - PW'({d2_q[31:0], 9'b0}) + PW'(d2_q[31:0]);
			end
			ppl_pkg::S_SM3: begin
				v_q     <= v_new;
				bit_q   <= bit_q >> 1;
				shade_q <= v_new;
			end
			default: ;
		endcase
		if (pend_load) begin
			pend_x_q     <= bx_q;
			pend_y_q     <= by_q;
			pend_shade_q <= shade_q;
		end
		if (out_load) begin
			out_found_q <= out_from_pend;
			out_last_q  <= (state_q == ppl_pkg::S_FIN);
			out_sx_q    <= out_from_pend ? ax_q : '0;
			out_sy_q    <= out_from_pend ? ay_q : '0;
			out_ex_q    <= out_from_pend ? pend_x_q : '0;
			out_ey_q    <= out_from_pend ? pend_y_q : '0;
			out_shade_q <= out_from_pend ? pend_shade_q : '0;
		end
	end

	assign cfg.ready   = 1'b1;
	assign rsp.valid   = out_valid_q;
	assign rsp.found   = out_found_q;
	assign rsp.start_x = out_sx_q;
	assign rsp.start_y = out_sy_q;
	assign rsp.end_x   = out_ex_q;
	assign rsp.end_y   = out_ey_q;
	assign rsp.shade   = out_shade_q;
	assign rsp.last    = out_last_q;

endmodule

// File: hdl/ppl_checker.sv
`timescale 1ns / 1ps

module ppl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         req_command,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_found,
	input logic [ppl_pkg::SHADE_W-1:0]  rsp_shade,
	input logic                         rsp_last
);

	// a stalled result beat holds its flags
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last) && $stable(rsp_found))
		else $error("rsp beat changed while stalled");

	// an accepted row keeps the block busy for at least the next cycle
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_command == ppl_pkg::CMD_ROW |=> !req_ready)
		else $error("ready right after a row command");

	// a row is still running while a non-final beat is shown
	a_mid_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("block idle with a non-final beat pending");

	// empty row beat is final and carries no shade
	a_empty_row: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_last && rsp_shade == '0)
		else $error("malformed empty-row beat");

	// shade stays below full scale
	a_shade_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_shade != {ppl_pkg::SHADE_W{1'b1}})
		else $error("shade out of range");

endmodule

bind point_pair_proximity_lines ppl_checker u_ppl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_command (req.command),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_found   (rsp.found),
	.rsp_shade   (rsp.shade),
	.rsp_last    (rsp.last)
);

// File: bench/point_pair_proximity_lines_tb.sv
`timescale 1ns / 1ps

module point_pair_proximity_lines_tb;

	localparam int NPTS         = ppl_pkg::POINTS_DEF;
	localparam int SHADE_FULL   = 255;
	localparam int SETTLE       = 40;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 39;
	localparam int COORD_MAX    = 65535;

	typedef struct packed {
		logic                        found;
		logic [ppl_pkg::COORD_W-1:0] start_x;
		logic [ppl_pkg::COORD_W-1:0] start_y;
		logic [ppl_pkg::COORD_W-1:0] end_x;
		logic [ppl_pkg::COORD_W-1:0] end_y;
		logic [ppl_pkg::SHADE_W-1:0] shade;
		logic                        last;
	} line_t;

	// Mirror of the point store and registers; queues the lines each row should give
	class pair_line_predictor;
		logic [ppl_pkg::COORD_W-1:0] xs [NPTS];
		logic [ppl_pkg::COORD_W-1:0] ys [NPTS];
		logic [ppl_pkg::COORD_W-1:0] threshold;
		logic [ppl_pkg::COUNT_W-1:0] count;
		line_t expected_lines [$];
		int mismatches;

		function new();
			threshold = ppl_pkg::MIN_DISTANCE_RST;
			count = ppl_pkg::POINT_COUNT_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [ppl_pkg::CFG_IDX_W-1:0] idx,
			logic [ppl_pkg::CFG_DATA_W-1:0] data);
			if (idx == ppl_pkg::REG_MIN_DISTANCE)
				threshold = data;
			else if (idx == ppl_pkg::REG_POINT_COUNT)
				count = data[ppl_pkg::COUNT_W-1:0];
		endfunction

		// largest v with v^2 * m2 <= 255^2 * d2
		function logic [ppl_pkg::SHADE_W-1:0] shade_of(longint unsigned d2,
			longint unsigned m2);
			longint unsigned scaled;
			longint unsigned vv;
			scaled = SHADE_FULL * SHADE_FULL * d2;
			for (int v = SHADE_FULL - 1; v > 0; v--) begin
				vv = v;
				if (vv * vv * m2 <= scaled)
					return v[ppl_pkg::SHADE_W-1:0];
			end
			return '0;
		endfunction

		function void note_command(logic cmd, logic [ppl_pkg::INDEX_W-1:0] idx,
			logic [ppl_pkg::COORD_W-1:0] px, logic [ppl_pkg::COORD_W-1:0] py);
			int span;
			int found_pairs;
			longint unsigned thr, m2, dx, dy, d2;
			line_t pair;
			if (cmd == ppl_pkg::CMD_LOAD) begin
				xs[idx] = px;
				ys[idx] = py;
				return;
			end
			span = (count > NPTS) ? NPTS : count;
			thr = threshold;
			m2 = thr * thr;
			found_pairs = 0;
			if (idx < span) begin
				for (int j = idx + 1; j < span; j++) begin
					dx = (xs[idx] > xs[j]) ? xs[idx] - xs[j] : xs[j] - xs[idx];
					dy = (ys[idx] > ys[j]) ? ys[idx] - ys[j] : ys[j] - ys[idx];
					d2 = dx * dx + dy * dy;
					if (d2 < m2) begin
						pair.found = 1'b1;
						pair.start_x = xs[idx];
						pair.start_y = ys[idx];
						pair.end_x = xs[j];
						pair.end_y = ys[j];
						pair.shade = shade_of(d2, m2);
						pair.last = 1'b0;
						expected_lines.push_back(pair);
						found_pairs++;
					end
				end
			end
			// empty row: a single all-zero beat; otherwise flag the final line
			if (found_pairs == 0) begin
				pair = '0;
				pair.last = 1'b1;
			end else begin
				pair = expected_lines.pop_back();
				pair.last = 1'b1;
			end
			expected_lines.push_back(pair);
		endfunction

		function void field_check(string name, logic [ppl_pkg::COORD_W-1:0] want,
			logic [ppl_pkg::COORD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_line(line_t got);
			line_t want;
			if (expected_lines.size() == 0) begin
				$error("line beat with nothing expected: %h", got);
				mismatches++;
				return;
			end
			want = expected_lines.pop_front();
			field_check("found", want.found, got.found);
			field_check("start_x", want.start_x, got.start_x);
			field_check("start_y", want.start_y, got.start_y);
			field_check("end_x", want.end_x, got.end_x);
			field_check("end_y", want.end_y, got.end_y);
			field_check("shade", want.shade, got.shade);
			field_check("last", want.last, got.last);
		endfunction

		function int waiting();
			return expected_lines.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ppl_req_if req_bus ();
	ppl_rsp_if rsp_bus ();
	ppl_cfg_if cfg_bus ();

	pair_line_predictor board = new();

	int src_idle_pct;
	int snk_stall_pct;
	int cur_threshold;
	int cur_count;
	int center_x;
	int center_y;

	point_pair_proximity_lines dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#(60_000_000);
		$display("point_pair_proximity_lines_tb: errors");
		$finish;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// line monitor
	always @(posedge clk) begin : line_monitor
		line_t got;
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
			got.found = rsp_bus.found;
			got.start_x = rsp_bus.start_x;
			got.start_y = rsp_bus.start_y;
			got.end_x = rsp_bus.end_x;
			got.end_y = rsp_bus.end_y;
			got.shade = rsp_bus.shade;
			got.last = rsp_bus.last;
			board.check_line(got);
		end
	end

	// one command beat; valid stays up until the next call or the next drain
	task automatic send_beat(logic cmd, int idx, int px, int py);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.command <= cmd;
		req_bus.index <= idx[ppl_pkg::INDEX_W-1:0];
		req_bus.pos_x <= px[ppl_pkg::COORD_W-1:0];
		req_bus.pos_y <= py[ppl_pkg::COORD_W-1:0];
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		board.note_command(cmd, idx[ppl_pkg::INDEX_W-1:0], px[ppl_pkg::COORD_W-1:0],
			py[ppl_pkg::COORD_W-1:0]);
	endtask

	task automatic write_register(logic [ppl_pkg::CFG_IDX_W-1:0] idx, int data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data[ppl_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		board.write_reg(idx, data[ppl_pkg::CFG_DATA_W-1:0]);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// stop sending, wait for every line, then let a trailing load settle
	task automatic wait_rows_done();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_registers(int min_dist, int cnt);
		wait_rows_done();
		write_register(ppl_pkg::REG_MIN_DISTANCE, min_dist);
		write_register(ppl_pkg::REG_POINT_COUNT, cnt);
		cur_threshold = min_dist;
		cur_count = cnt;
	endtask

	function automatic int near_coord(int c, int spread);
		int v;
		v = c + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	// mostly clustered loads and rows inside the search range, some noise
	task automatic send_random_command();
		int span;
		int spread;
		int idx;
		bit noise;
		span = (cur_count > NPTS) ? NPTS : cur_count;
		spread = (cur_threshold == 0) ? int'(ppl_pkg::MIN_DISTANCE_RST) : cur_threshold;
		noise = ($urandom_range(99) < 10);
		if ($urandom_range(99) < 50) begin
			idx = (noise || span == 0) ? $urandom_range(NPTS - 1) : $urandom_range(span - 1);
			if (noise)
				send_beat(ppl_pkg::CMD_LOAD, idx, $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX));
			else
				send_beat(ppl_pkg::CMD_LOAD, idx, near_coord(center_x, spread),
					near_coord(center_y, spread));
		end else begin
			idx = (noise || span == 0) ? $urandom_range(NPTS - 1) : $urandom_range(span - 1);
			send_beat(ppl_pkg::CMD_ROW, idx, $urandom_range(COORD_MAX),
				$urandom_range(COORD_MAX));
		end
	endtask

	initial begin
		int min_dist;
		int cnt;
		arst_n = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		req_bus.valid = 1'b0;
		req_bus.command = ppl_pkg::CMD_LOAD;
		req_bus.index = '0;
		req_bus.pos_x = '0;
		req_bus.pos_y = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = ppl_pkg::REG_MIN_DISTANCE;
		cfg_bus.data = '0;
		rsp_bus.ready = 1'b0;
		center_x = $urandom_range(COORD_MAX);
		center_y = $urandom_range(COORD_MAX);
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed: threshold edge, identical points, extremes, empty rows
		set_registers(1600, 5);
		send_beat(ppl_pkg::CMD_LOAD, 0, 0, 0);
		send_beat(ppl_pkg::CMD_LOAD, 1, COORD_MAX, COORD_MAX);
		send_beat(ppl_pkg::CMD_LOAD, 2, 1599, 0);
		send_beat(ppl_pkg::CMD_LOAD, 3, 0, 1600);
		send_beat(ppl_pkg::CMD_LOAD, 4, 0, 0);
		send_beat(ppl_pkg::CMD_LOAD, NPTS - 1, COORD_MAX, 0);
		send_beat(ppl_pkg::CMD_ROW, 0, COORD_MAX, COORD_MAX);
		send_beat(ppl_pkg::CMD_ROW, 1, 0, 0);
		send_beat(ppl_pkg::CMD_ROW, 2, 0, 0);
		send_beat(ppl_pkg::CMD_ROW, 4, 0, 0);
		send_beat(ppl_pkg::CMD_ROW, 5, 0, 0);
		send_beat(ppl_pkg::CMD_ROW, NPTS - 1, 0, 0);
		// zero threshold: nothing is ever close enough
		set_registers(0, 5);
		send_beat(ppl_pkg::CMD_ROW, 0, 0, 0);
		// smallest threshold: only coincident points pair up
		set_registers(1, 5);
		send_beat(ppl_pkg::CMD_ROW, 0, 0, 0);
		// too few points for any pair
		set_registers(COORD_MAX, 0);
		send_beat(ppl_pkg::CMD_ROW, 0, 0, 0);
		set_registers(COORD_MAX, 1);
		send_beat(ppl_pkg::CMD_ROW, 0, 0, 0);
		// count above the store size clamps
		set_registers(COORD_MAX, 127);
		send_beat(ppl_pkg::CMD_ROW, NPTS - 1, 0, 0);

		// fill the whole store so every row reads written slots
		set_registers(1600, NPTS);
		for (int i = 0; i < NPTS; i++)
			send_beat(ppl_pkg::CMD_LOAD, i, near_coord(center_x, 1600),
				near_coord(center_y, 1600));

		// random phases over register settings and idling mixes
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin min_dist = 1600; cnt = NPTS; end
				1: begin min_dist = COORD_MAX; cnt = NPTS; end
				2: begin min_dist = 1; cnt = NPTS; end
				3: begin
					min_dist = $urandom_range(1, COORD_MAX);
					cnt = $urandom_range(2, NPTS);
				end
				4: begin min_dist = 1600; cnt = 2; end
				5: begin min_dist = COORD_MAX; cnt = 127; end
				6: begin min_dist = $urandom_range(2, 200); cnt = 100; end
				7: begin min_dist = 0; cnt = NPTS; end
				8: begin
					min_dist = $urandom_range(1, COORD_MAX);
					cnt = $urandom_range(0, 127);
				end
				default: begin min_dist = 1600; cnt = NPTS; end
			endcase
			set_registers(min_dist, cnt);
			case (p % 4)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 56; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 56; end
				default: begin src_idle_pct = 10; snk_stall_pct = 10; end
			endcase
			repeat (PHASE_ITEMS) send_random_command();
		end

		wait_rows_done();
		if (board.mismatches == 0)
			$display("point_pair_proximity_lines_tb: clean");
		else
			$display("point_pair_proximity_lines_tb: errors");
		$finish;
	end

endmodule
